[rtl/core/ramp_pkg.sv]
// ----------------------------------------------------------------------------
// Range add max prefix package
// Shared widths, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package ramp_pkg;

    localparam int IDX_W   = 13;
    localparam int VAL_W   = 30;
    localparam int STORE_W = 64;
    localparam int MAX_W   = 63;

    localparam logic [IDX_W-1:0] ARRAY_SIZE_RESET = 13'd4096;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDL,
        S_WRL,
        S_WRR,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } ramp_state_t;

endpackage

[rtl/core/range_add_max_prefix.sv]
// ----------------------------------------------------------------------------
// Range add max prefix
// Difference-store range add; a query marked last triggers a prefix scan
// that emits the largest prefix sum, floored at zero, and clears the store.
// ----------------------------------------------------------------------------
// After acceptance the left entry is read, then written while the right entry
// is read, then the right entry is written; the next query is accepted only
// once these steps are done and the sequencer is back in idle.
// After a last query the store is scanned and drained, with any wait for an earlier
// result that is still held, before the result appears and the input is ready again.
// After reset the store is cleared entry by entry with in_ready low.
module range_add_max_prefix
    import ramp_pkg::*;
#(
    parameter int MAX_SIZE = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IDX_W-1:0]   left_index,
    input  logic [IDX_W-1:0]   right_index,
    input  logic [VAL_W-1:0]   add_value,
    input  logic               last_query,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MAX_W-1:0]   peak_value
);

    localparam int AW = $clog2(MAX_SIZE);
    localparam int CW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
    localparam logic [CW-1:0] MAX_SIZE_C = CW'(MAX_SIZE);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(MAX_SIZE - 1);

    ramp_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   array_size_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg;
    logic               pend_use_reg;
    logic               out_valid_reg, out_valid_next;
    logic [MAX_W-1:0]   peak_value_reg;
    logic [STORE_W-1:0] running_reg, best_reg;
    logic [AW-1:0]      laddr_reg, raddr_reg;
    logic               apply_reg, right_in_reg, last_reg;
    logic [VAL_W-1:0]   value_reg;

    logic [CW-1:0]      ext_size, eff_size, left_ext, right_ext, left_m1;
    logic               query_ok, right_in;
    logic               accept;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [STORE_W-1:0] mem_wdata, mem_rdata;
    logic [STORE_W-1:0] running_sum;

    assign ext_size  = CW'(array_size_reg);
    assign eff_size  = (ext_size > MAX_SIZE_C) ? MAX_SIZE_C : ext_size;
    assign left_ext  = CW'(left_index);
    assign right_ext = CW'(right_index);
    assign left_m1   = left_ext - CW'(1);
    assign query_ok  = (left_ext != '0) && (right_ext != '0) && (left_ext <= eff_size)
                       && (right_ext <= eff_size) && (left_ext <= right_ext);
    assign right_in  = right_ext < eff_size;
    assign accept    = in_valid && in_ready;

    assign running_sum = running_reg + mem_rdata;

    assign out_valid  = out_valid_reg;
    assign peak_value = peak_value_reg;

    ramp_ram #(
        .WIDTH(STORE_W),
        .DEPTH(MAX_SIZE)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_raddr      = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = '0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_RDL;
                end
            end
            S_RDL:
            begin
                mem_raddr  = laddr_reg;
                state_next = S_WRL;
            end
            S_WRL:
            begin
                mem_we     = apply_reg;
                mem_waddr  = laddr_reg;
                mem_wdata  = mem_rdata + STORE_W'(value_reg);
                mem_raddr  = raddr_reg;
                state_next = S_WRR;
            end
            S_WRR:
            begin
                mem_we    = apply_reg && right_in_reg;
                mem_waddr = raddr_reg;
                mem_wdata = mem_rdata - STORE_W'(value_reg);
                idx_next  = '0;
                state_next = last_reg ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                mem_raddr = idx_reg;
                pend_next = 1'b1;
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == LAST_ADDR)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            array_size_reg <= ARRAY_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                array_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            laddr_reg    <= left_m1[AW-1:0];
            raddr_reg    <= right_ext[AW-1:0];
            apply_reg    <= query_ok;
            right_in_reg <= right_in;
            value_reg    <= add_value;
            last_reg     <= last_query;
        end

        pend_addr_reg <= idx_reg;
        pend_use_reg  <= CW'(idx_reg) < eff_size;

        if (state_reg == S_WRR)
        begin
            running_reg <= '0;
            best_reg    <= '0;
        end
        else if (pend_reg && pend_use_reg)
        begin
            running_reg <= running_sum;
            if ($signed(running_sum) > $signed(best_reg))
            begin
                best_reg <= running_sum;
            end
        end

        if (state_reg == S_EMIT && (!out_valid_reg || out_ready))
        begin
            peak_value_reg <= best_reg[MAX_W-1:0];
        end
    end

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("Scan write-back outside the scan.");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_RDL)
        else $error("Accepted item did not start an update.");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !out_ready) |=> state_reg == S_EMIT)
        else $error("Result dropped while output is stalled.");

    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> pend_addr_reg != idx_reg)
        else $error("Scan read and write hit the same entry.");

    a_best_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> !best_reg[STORE_W-1])
        else $error("Scan maximum is negative.");

endmodule

[rtl/core/ramp_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ramp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range add max prefix testbench
// Drives range-add queries in batches closed by a last query and checks each
// maximum against a typed peak or local difference-store predictor. A short
// directed table comes first, then random batches over several array sizes,
// with random sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import ramp_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int HOLD_CYCLES = 12000;
    localparam int QUIET_CYCLES = 8;
    localparam int PHASE_COUNT = 9;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic [IDX_W-1:0] l_idx;
        logic [IDX_W-1:0] r_idx;
        logic [VAL_W-1:0] amount;
        logic             is_last;
        logic             has_peak;
        logic [MAX_W-1:0] peak;
    } query_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic [VAL_W-1:0] add_value;
    logic             last_query;
    logic             out_valid;
    logic             out_ready;
    logic [MAX_W-1:0] peak_value;

    logic [STORE_W-1:0] diff_store [STORE_DEPTH];
    logic [IDX_W-1:0]   array_size_cfg;
    logic [MAX_W-1:0]   expected_peaks [$];
    logic [MAX_W-1:0]   front_peak;
    int                 error_count;
    int                 burst_left;
    int                 ready_run;
    bit                 ready_stalled;
    bit                 hold_request;

    query_row_t directed_rows [18] = '{
        '{13'd1,    13'd1,    30'd0,      1'b1, 1'b1, 63'd0},
        '{13'd1,    13'd4096, VAL_MAX,    1'b1, 1'b1, 63'd1073741823},
        '{13'd4096, 13'd4096, VAL_MAX,    1'b0, 1'b0, 63'd0},
        '{13'd1,    13'd4096, VAL_MAX,    1'b1, 1'b1, 63'd2147483646},
        '{13'd0,    13'd5,    30'd100,    1'b0, 1'b0, 63'd0},
        '{13'd5,    13'd4097, 30'd100,    1'b0, 1'b0, 63'd0},
        '{13'd8191, 13'd8191, VAL_MAX,    1'b0, 1'b0, 63'd0},
        '{13'd10,   13'd5,    30'd100,    1'b0, 1'b0, 63'd0},
        '{13'd3,    13'd3,    30'd7,      1'b1, 1'b1, 63'd7},
        '{13'd1,    13'd10,   30'd5,      1'b0, 1'b0, 63'd0},
        '{13'd5,    13'd20,   30'd6,      1'b0, 1'b0, 63'd0},
        '{13'd8,    13'd8,    30'd9,      1'b1, 1'b1, 63'd20},
        '{13'd0,    13'd0,    30'd5,      1'b1, 1'b1, 63'd0},
        '{13'd2,    13'd3,    VAL_MAX,    1'b0, 1'b0, 63'd0},
        '{13'd3,    13'd4096, VAL_MAX,    1'b1, 1'b1, 63'd2147483646},
        '{13'd100,  13'd4000, 30'd12345,  1'b0, 1'b0, 63'd0},
        '{13'd2000, 13'd2100, 30'd777777, 1'b1, 1'b0, 63'd0},
        '{13'd4096, 13'd4096, 30'd1,      1'b1, 1'b1, 63'd1}
    };

    range_add_max_prefix #(
        .MAX_SIZE(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .left_index(left_index),
        .right_index(right_index),
        .add_value(add_value),
        .last_query(last_query),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .peak_value(peak_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic predict_query(input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r,
                                 input logic [VAL_W-1:0] v, input logic lq,
                                 output bit produces, output logic [MAX_W-1:0] peak);
        int unsigned sz;
        logic [STORE_W-1:0] running;
        logic [STORE_W-1:0] best;
        sz = (array_size_cfg > STORE_DEPTH) ? STORE_DEPTH : array_size_cfg;
        if (l >= 1 && r >= 1 && l <= sz && r <= sz && l <= r)
        begin
            diff_store[l - 1] += 64'(v);
            if (r < sz)
                diff_store[r] -= 64'(v);
        end
        produces = lq;
        peak = '0;
        if (lq)
        begin
            running = '0;
            best = '0;
            for (int i = 0; i < sz; i++)
            begin
                running += diff_store[i];
                if ($signed(running) > $signed(best))
                    best = running;
            end
            foreach (diff_store[i])
                diff_store[i] = '0;
            peak = best[MAX_W-1:0];
        end
    endtask

    task automatic offer_query(input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r,
                               input logic [VAL_W-1:0] v, input logic lq,
                               input logic has_peak, input logic [MAX_W-1:0] typed_peak);
        bit produces;
        logic [MAX_W-1:0] peak;
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        left_index <= l;
        right_index <= r;
        add_value <= v;
        last_query <= lq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_query(l, r, v, lq, produces, peak);
        if (produces)
            expected_peaks.push_back(has_peak ? typed_peak : peak);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic offer_random_query(input logic lq);
        int unsigned sz;
        int unsigned l;
        int unsigned r;
        int unsigned mode;
        logic [VAL_W-1:0] v;
        sz = (array_size_cfg > STORE_DEPTH) ? STORE_DEPTH : array_size_cfg;
        mode = $urandom_range(0, 9);
        if (mode == 0 || sz == 0)
        begin
            l = $urandom;
            r = $urandom;
        end
        else if (mode == 1 && sz >= 2)
        begin
            r = $urandom_range(1, sz - 1);
            l = $urandom_range(r + 1, sz);
        end
        else
        begin
            l = (mode == 3) ? 1 : $urandom_range(1, sz);
            r = (mode == 2) ? sz : $urandom_range(l, sz);
        end
        case ($urandom_range(0, 3))
            0: v = VAL_MAX;
            1: v = VAL_W'($urandom_range(0, 255));
            default: v = VAL_W'($urandom);
        endcase
        offer_query(l[IDX_W-1:0], r[IDX_W-1:0], v, lq, 1'b0, '0);
    endtask

    task automatic wait_for_peaks();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_array_size(input logic [IDX_W-1:0] size);
        wait_for_peaks();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        array_size_cfg = size;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        ready_run = 0;
        ready_stalled = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (ready_run == 0)
                begin
                    ready_stalled = !ready_stalled;
                    if (ready_stalled)
                        ready_run = $urandom_range(1, 8);
                    else
                        ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                                : $urandom_range(1, 4);
                end
                ready_run--;
                out_ready <= !ready_stalled;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_peaks.size() == 0)
            begin
                $display("%0t: unexpected peak_value, expected none, actual %0d", $time,
                         peak_value);
                error_count++;
            end
            else
            begin
                front_peak = expected_peaks.pop_front();
                if (peak_value !== front_peak)
                begin
                    $display("%0t: peak_value expected %0d actual %0d", $time, front_peak,
                             peak_value);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int batch_len;
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        left_index = '0;
        right_index = '0;
        add_value = '0;
        last_query = 1'b0;
        hold_request = 1'b0;
        error_count = 0;
        burst_left = 0;
        array_size_cfg = ARRAY_SIZE_RESET;
        foreach (diff_store[i])
            diff_store[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_query(directed_rows[i].l_idx, directed_rows[i].r_idx, directed_rows[i].amount,
                        directed_rows[i].is_last, directed_rows[i].has_peak,
                        directed_rows[i].peak);

        // The receiver holds off long enough for a finished scan to back up the input.
        hold_request = 1'b1;
        for (int k = 0; k < 4; k++)
            offer_random_query(k == 3);
        for (int k = 0; k < 6; k++)
            offer_random_query(k == 5);
        wait_for_peaks();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: write_array_size(13'd1);
                1: write_array_size(13'd8191);
                2: write_array_size(13'd0);
                3: write_array_size(IDX_W'($urandom_range(2, 16)));
                4: write_array_size(13'd4096);
                default:
                    write_array_size(IDX_W'(($urandom_range(0, 5) == 0)
                                            ? $urandom_range(4097, 8191)
                                            : $urandom_range(1, 4096)));
            endcase
            for (int b = 0; b < 5; b++)
            begin
                batch_len = $urandom_range(1, 25);
                for (int k = 0; k < batch_len; k++)
                    offer_random_query(k == batch_len - 1);
            end
            // Leave partial sums behind so the next size setting scans over them.
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4)) offer_random_query(1'b0);
        end

        wait_for_peaks();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ramp_pkg.sv
rtl/core/ramp_ram.sv
rtl/core/range_add_max_prefix.sv
tb/tb.sv
